### rtl/psu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// PNG scanline unfilter package
// Shared widths, register indexes, filter codes, the stage record passed from
// the row controller to the reconstruction stage, and the Paeth predictor.
// ============================================================================
package psu_pkg;

    localparam int BYTE_W = 8;
    localparam int BPP_W  = 4;
    localparam int LINE_W = 14;
    localparam int CFG_W  = LINE_W;

    localparam int DEF_MAX_LINE_BYTES  = 8192;
    localparam int DEF_MAX_PIXEL_BYTES = 8;

    // Configuration register indexes.
    localparam logic CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic CFG_LINE_BYTES      = 1'b1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // One request held between the input side and the reconstruction stage.
    typedef struct packed {
        logic              is_error;
        filter_t           filter;
        logic              first_row;
        logic              last;
        logic              has_left;
        logic [BYTE_W-1:0] data;
    } stage_t;

    function automatic logic [BYTE_W-1:0] paeth_pred(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [9:0]         pa;
        logic [9:0]         pb;
        logic [9:0]         pc;
        logic [BYTE_W-1:0]  res;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        // Ties go to left, then above, then upper-left.
        if ((pa <= pb) && (pa <= pc)) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

### rtl/psu_line_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// PNG scanline unfilter line store
// Single write port, single read port RAM holding the previous reconstructed
// row, with registered read data.
// ============================================================================
module psu_line_mem #(
    parameter int MAX_LINE_BYTES = psu_pkg::DEF_MAX_LINE_BYTES,
    parameter int ADDR_W         = $clog2(MAX_LINE_BYTES)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [psu_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [psu_pkg::BYTE_W-1:0] rd_data
);
    import psu_pkg::*;

    logic [BYTE_W-1:0] mem [0:MAX_LINE_BYTES-1];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/psu_row_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// PNG scanline unfilter row controller
// Holds the configuration registers and the row state, takes input requests,
// issues the line store read and loads the reconstruction stage register.
// ============================================================================
module psu_row_ctrl #(
    parameter int MAX_LINE_BYTES  = psu_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
    parameter int ADDR_W          = $clog2(MAX_LINE_BYTES),
    parameter int SEL_W           = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [psu_pkg::BYTE_W-1:0] in_byte,
    input  logic                       start_of_image,
    input  logic                       out_free,
    output logic                       s1_valid,
    output psu_pkg::stage_t            s1_item,
    output logic [ADDR_W-1:0]          s1_idx,
    output logic [SEL_W-1:0]           s1_sel,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr
);
    import psu_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int CW    = (CNT_W > LINE_W) ? CNT_W : LINE_W;
    localparam logic [CW-1:0]    MAX_LEN_C = CW'(MAX_LINE_BYTES);
    localparam logic [BPP_W-1:0] MAX_BPP_C = BPP_W'(MAX_PIXEL_BYTES);

    logic [BPP_W-1:0]  bpp_reg;
    logic [LINE_W-1:0] line_reg;
    logic              expect_filter_reg, expect_filter_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    filter_t           filter_reg, filter_next;
    logic              first_row_reg, first_row_next;
    logic              error_hold_reg, error_hold_next;
    logic              s1_valid_reg, s1_valid_next;
    stage_t            s1_item_reg, s1_item_next;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic [SEL_W-1:0]  s1_sel_reg;

    logic [BPP_W-1:0] bpp_eff;
    logic [CW-1:0]    line_ext;
    logic [CW-1:0]    len_eff;
    logic             last;
    logic             has_left;
    logic             advance;
    logic             accept;
    logic             load_s1;
    logic             eff_expect;
    logic             eff_hold;

    // Out-of-range settings are clamped into the supported range.
    assign bpp_eff  = (bpp_reg == '0) ? BPP_W'(1) :
                      ((bpp_reg > MAX_BPP_C) ? MAX_BPP_C : bpp_reg);
    assign line_ext = CW'(line_reg);
    assign len_eff  = (line_ext == '0) ? CW'(1) :
                      ((line_ext > MAX_LEN_C) ? MAX_LEN_C : line_ext);
    assign last     = (CW'(idx_reg) + CW'(1)) >= len_eff;
    assign has_left = CW'(idx_reg) >= CW'(bpp_eff);

    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign eff_expect = start_of_image || expect_filter_reg;
    assign eff_hold   = !start_of_image && error_hold_reg;

    always_comb
    begin
        expect_filter_next = expect_filter_reg;
        idx_next           = idx_reg;
        filter_next        = filter_reg;
        first_row_next     = first_row_reg;
        error_hold_next    = error_hold_reg;
        load_s1            = 1'b0;
        rd_en              = 1'b0;
        s1_item_next.is_error  = 1'b0;
        s1_item_next.filter    = filter_reg;
        s1_item_next.first_row = first_row_reg;
        s1_item_next.last      = last;
        s1_item_next.has_left  = has_left;
        s1_item_next.data      = in_byte;
        if (accept)
        begin
            if (start_of_image)
            begin
                // A new image abandons any row in progress.
                expect_filter_next = 1'b1;
                idx_next           = '0;
                filter_next        = FILT_NONE;
                first_row_next     = 1'b1;
                error_hold_next    = 1'b0;
            end
            if (!eff_hold)
            begin
                if (eff_expect)
                begin
                    if (in_byte > BYTE_W'(FILT_PAETH))
                    begin
                        error_hold_next       = 1'b1;
                        load_s1               = 1'b1;
                        s1_item_next.is_error = 1'b1;
                    end
                    else
                    begin
                        filter_next        = filter_t'(in_byte[2:0]);
                        expect_filter_next = 1'b0;
                        idx_next           = '0;
                    end
                end
                else
                begin
                    load_s1 = 1'b1;
                    rd_en   = 1'b1;
                    if (last)
                    begin
                        expect_filter_next = 1'b1;
                        first_row_next     = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
        end
    end

    assign s1_valid_next = load_s1 ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg           <= BPP_W'(1);
            line_reg          <= LINE_W'(1);
            expect_filter_reg <= 1'b1;
            idx_reg           <= '0;
            filter_reg        <= FILT_NONE;
            first_row_reg     <= 1'b1;
            error_hold_reg    <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_BYTES_PER_PIXEL))
            begin
                bpp_reg <= cfg_wdata[BPP_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_LINE_BYTES))
            begin
                line_reg <= cfg_wdata[LINE_W-1:0];
            end
            expect_filter_reg <= expect_filter_next;
            idx_reg           <= idx_next;
            filter_reg        <= filter_next;
            first_row_reg     <= first_row_next;
            error_hold_reg    <= error_hold_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_item_reg <= s1_item_next;
            s1_idx_reg  <= idx_reg;
            s1_sel_reg  <= SEL_W'(bpp_eff - BPP_W'(1));
        end
    end

    assign rd_addr  = idx_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_idx   = s1_idx_reg;
    assign s1_sel   = s1_sel_reg;

endmodule

### rtl/psu_recon.sv
`timescale 1ns / 1ps
// ============================================================================
// PNG scanline unfilter reconstruction stage
// Keeps the left and upper-left byte history, forms the filter prediction,
// adds it to the filtered byte and holds the result in the output register.
// ============================================================================
module psu_recon #(
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
    parameter int SEL_W           = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s1_valid,
    input  psu_pkg::stage_t            s1_item,
    input  logic [SEL_W-1:0]           s1_sel,
    input  logic [psu_pkg::BYTE_W-1:0] above,
    output logic                       out_free,
    output logic                       wr_en,
    output logic [psu_pkg::BYTE_W-1:0] wr_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [psu_pkg::BYTE_W-1:0] recon_byte,
    output logic                       end_of_row,
    output logic                       status
);
    import psu_pkg::*;

    // Entry k holds the byte k+1 positions back in the current row.
    logic [BYTE_W-1:0] left_reg [0:MAX_PIXEL_BYTES-1];
    logic [BYTE_W-1:0] upleft_reg [0:MAX_PIXEL_BYTES-1];

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] recon_reg;
    logic              eor_reg;
    logic              status_reg;

    logic              advance;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W:0]   ab_sum;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] recon;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid && out_free;

    assign b      = s1_item.first_row ? '0 : above;
    assign a      = s1_item.has_left ? left_reg[s1_sel] : '0;
    assign c      = s1_item.has_left ? upleft_reg[s1_sel] : '0;
    assign ab_sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        unique case (s1_item.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth_pred(a, b, c);
            default:    pred = '0;
        endcase
    end

    assign recon   = s1_item.data + pred;
    assign wr_en   = advance && !s1_item.is_error;
    assign wr_data = recon;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_reg[0]   <= recon;
            upleft_reg[0] <= b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i]   <= left_reg[i-1];
                upleft_reg[i] <= upleft_reg[i-1];
            end
        end
    end

    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s1_item.is_error)
            begin
                recon_reg  <= '0;
                eor_reg    <= 1'b0;
                status_reg <= 1'b1;
            end
            else
            begin
                recon_reg  <= recon;
                eor_reg    <= s1_item.last;
                status_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign recon_byte = recon_reg;
    assign end_of_row = eor_reg;
    assign status     = status_reg;

endmodule

### rtl/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// ============================================================================
// PNG scanline unfilter
// Reverses PNG filter method 0 (None, Sub, Up, Average, Paeth) on a
// non-interlaced byte stream, one byte per request.
// ============================================================================
// The block takes one byte per clock and, while out_ready stays high, sustains
// one reconstructed byte per clock. At the accepting edge a data byte enters the
// middle stage register and the previous row is read from the line store into
// its read register; the prediction is then formed and, once it is free, the
// output register is loaded. A stalled output holds the request waiting in the
// middle stage and then stalls the input, so at most two requests are in
// flight. Filter-type bytes and bytes dropped after an unknown filter type
// produce no result; an unknown filter type produces one result with status
// set, after which input is discarded until a byte marked start_of_image.
// Configuration writes take effect at once and are meant to be made between
// requests. The line store needs no clearing after reset: the first row of
// every image treats the row above as zero.
module png_scanline_unfilter #(
    parameter int MAX_LINE_BYTES  = psu_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [psu_pkg::BYTE_W-1:0] in_byte,
    input  logic                       start_of_image,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [psu_pkg::BYTE_W-1:0] recon_byte,
    output logic                       end_of_row,
    output logic                       status
);
    import psu_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE_BYTES);
    localparam int SEL_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic              out_free;
    logic              s1_valid;
    stage_t            s1_item;
    logic [ADDR_W-1:0] s1_idx;
    logic [SEL_W-1:0]  s1_sel;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;

    psu_row_ctrl #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .ADDR_W          (ADDR_W),
        .SEL_W           (SEL_W)
    ) u_row_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .start_of_image (start_of_image),
        .out_free       (out_free),
        .s1_valid       (s1_valid),
        .s1_item        (s1_item),
        .s1_idx         (s1_idx),
        .s1_sel         (s1_sel),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr)
    );

    psu_line_mem #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .ADDR_W         (ADDR_W)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    psu_recon #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .SEL_W           (SEL_W)
    ) u_recon (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .s1_sel     (s1_sel),
        .above      (rd_data),
        .out_free   (out_free),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .recon_byte (recon_byte),
        .end_of_row (end_of_row),
        .status     (status)
    );

endmodule
